// ===== rtl/psct_pkg.sv =====
package psct_pkg;

	localparam int COORD_BITS = 24;
	localparam int ANGLE_BITS = 16;

	localparam int PIVOT_BITS = 17;
	localparam int UNIT_Q16   = 65536;
	localparam int MUL_W      = COORD_BITS + 18;
	localparam int OFS_W      = MUL_W - 12;
	localparam int PROD_W     = OFS_W + 18;
	localparam int SUM_W      = PROD_W + 1;
	localparam int RES_W      = SUM_W - 20 + 1;

	localparam int IN_W  = 2 * COORD_BITS + 2 * (COORD_BITS - 1) + 2 * PIVOT_BITS + ANGLE_BITS;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TW = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic signed [32:0] ATAN [CORDIC_STEPS] = '{
		33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
		33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
		33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
		33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D
	};

	localparam logic [1:0] CORNER_BL = 2'd0;
	localparam logic [1:0] CORNER_BR = 2'd1;
	localparam logic [1:0] CORNER_TR = 2'd2;
	localparam logic [1:0] CORNER_TL = 2'd3;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic [COORD_BITS-2:0]        w;
		logic [COORD_BITS-2:0]        h;
		logic [PIVOT_BITS-1:0]        pu;
		logic [PIVOT_BITS-1:0]        pv;
		logic                         mir;
		logic [1:0]                   quad;
		logic signed [32:0]           x;
		logic signed [32:0]           y;
		logic signed [32:0]           z;
		logic signed [MUL_W-1:0]      pw;
		logic signed [MUL_W-1:0]      rw;
		logic signed [MUL_W-1:0]      ph;
		logic signed [MUL_W-1:0]      bh;
		logic signed [OFS_W-1:0]      lx;
		logic signed [OFS_W-1:0]      rx;
		logic signed [OFS_W-1:0]      ty;
		logic signed [OFS_W-1:0]      by;
		logic signed [17:0]           cs;
		logic signed [17:0]           sn;
	} sprite_t;

	typedef struct packed {
		logic signed [PROD_W-1:0]     a;
		logic signed [PROD_W-1:0]     b;
		logic signed [PROD_W-1:0]     c;
		logic signed [PROD_W-1:0]     d;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic [1:0]                   idx;
	} corner_t;

endpackage

// ===== rtl/pivot_sprite_corner_transform.sv =====
// Stages p_s1..p_s6, holding register ser_q, then c_s1, rx_s2, ox_s3 carry a sprite; corners
// leave the single corner datapath one a cycle unless m_tready stalls. A sprite is taken only
// if ser_q is empty or on its last corner. CORDIC: 4 micro-rotations per stage, four stages.
// Reset: arst_n clears every valid bit and the corner counter at once; data registers keep
// whatever they held.
module pivot_sprite_corner_transform
	import psct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, size_w, size_h, pivot_u, pivot_v, angle
	input  logic [IN_TW-1:0]  s_tdata,
	// mirror
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// corner_x, corner_y
	output logic [OUT_TW-1:0] m_tdata,
	// corner_index
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	localparam int CB = COORD_BITS;
	localparam int AB = ANGLE_BITS;
	localparam int O_PY = CB;
	localparam int O_W  = 2 * CB;
	localparam int O_H  = O_W + CB - 1;
	localparam int O_PU = O_H + CB - 1;
	localparam int O_PV = O_PU + PIVOT_BITS;
	localparam int O_AN = O_PV + PIVOT_BITS;

	function automatic sprite_t cordic4(sprite_t f, int base);
		sprite_t r;
		logic signed [32:0] xs, ys;
		r = f;
		for (int j = 0; j < 4; j++) begin
			xs = r.x >>> (base + j);
			ys = r.y >>> (base + j);
			if (!r.z[32]) begin
				r.x = r.x - ys;
				r.y = r.y + xs;
				r.z = r.z - ATAN[base + j];
			end else begin
				r.x = r.x + ys;
				r.y = r.y - xs;
				r.z = r.z + ATAN[base + j];
			end
		end
		return r;
	endfunction

	function automatic logic signed [17:0] unit_round(logic signed [32:0] v);
		logic signed [32:0] t;
		t = (v + 33'sd8192) >>> 14;
		if (t > 33'sd65536) begin
			return 18'sd65536;
		end else if (t < -33'sd65536) begin
			return -18'sd65536;
		end
		return t[17:0];
	endfunction

	function automatic logic signed [OFS_W-1:0] ofs_round(logic signed [MUL_W-1:0] v);
		logic signed [MUL_W-1:0] t;
		t = (v + MUL_W'(2048)) >>> 12;
		return t[OFS_W-1:0];
	endfunction

	sprite_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, ser_q;
	sprite_t n1, n2, n3, n4, n5, n6;
	logic    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, ser_v_q;
	logic [1:0] cnt_q;
	corner_t c_s1, cn1;
	logic    cv_s1, cv_s2, cv_s3;
	logic signed [RES_W-1:0] rx_s2, ry_s2;
	logic [1:0] idx_s2, idx_s3;
	logic signed [CB-1:0] ox_s3, oy_s3;
	logic    en, fe;

	// The whole datapath holds while a finished corner word waits at the output.
	assign en = !cv_s3 || m_tready;
	assign fe = en && (!ser_v_q || cnt_q == CORNER_TL);
	assign s_tready = fe;

	always_comb begin
		logic [PIVOT_BITS-1:0] pu, pv;
		n1 = '0;
		pu = s_tdata[O_PU +: PIVOT_BITS];
		pv = s_tdata[O_PV +: PIVOT_BITS];
		n1.px   = s_tdata[0 +: CB];
		n1.py   = s_tdata[O_PY +: CB];
		n1.w    = s_tdata[O_W +: CB-1];
		n1.h    = s_tdata[O_H +: CB-1];
		n1.pu   = (pu > PIVOT_BITS'(UNIT_Q16)) ? PIVOT_BITS'(UNIT_Q16) : pu;
		n1.pv   = (pv > PIVOT_BITS'(UNIT_Q16)) ? PIVOT_BITS'(UNIT_Q16) : pv;
		n1.mir  = s_tuser;
		n1.quad = s_tdata[O_AN + AB - 2 +: 2];
		n1.x    = CORDIC_GAIN;
		n1.y    = '0;
		n1.z    = $signed({3'b000, s_tdata[O_AN +: AB-2], {(32-AB){1'b0}}});
	end

	always_comb begin
		logic signed [17:0] spu, spv, upu, dpv;
		logic signed [CB-1:0] sw, sh;
		n2  = cordic4(p_s1, 0);
		spu = $signed({1'b0, p_s1.pu});
		spv = $signed({1'b0, p_s1.pv});
		upu = 18'sd65536 - spu;
		dpv = spv - 18'sd65536;
		sw  = $signed({1'b0, p_s1.w});
		sh  = $signed({1'b0, p_s1.h});
		n2.pw = sw * spu;
		n2.rw = sw * upu;
		n2.ph = sh * spv;
		n2.bh = sh * dpv;
	end

	always_comb begin
		logic signed [OFS_W-1:0] l, r;
		n3 = cordic4(p_s2, 4);
		l  = ofs_round(-p_s2.pw);
		r  = ofs_round(p_s2.rw);
		n3.lx = p_s2.mir ? -l : l;
		n3.rx = p_s2.mir ? -r : r;
		n3.ty = ofs_round(p_s2.ph);
		n3.by = ofs_round(p_s2.bh);
	end

	assign n4 = cordic4(p_s3, 8);
	assign n5 = cordic4(p_s4, 12);

	always_comb begin
		logic signed [17:0] c, s;
		n6 = p_s5;
		c  = unit_round(p_s5.x);
		s  = unit_round(p_s5.y);
		case (p_s5.quad)
			2'd0: begin n6.cs = c;  n6.sn = s;  end
			2'd1: begin n6.cs = -s; n6.sn = c;  end
			2'd2: begin n6.cs = -c; n6.sn = -s; end
			default: begin n6.cs = s; n6.sn = -c; end
		endcase
	end

	always_comb begin
		logic signed [OFS_W-1:0] ox, oy;
		ox = (cnt_q == CORNER_BR || cnt_q == CORNER_TR) ? ser_q.rx : ser_q.lx;
		oy = (cnt_q == CORNER_TR || cnt_q == CORNER_TL) ? ser_q.ty : ser_q.by;
		cn1.a   = ox * ser_q.cs;
		cn1.b   = oy * ser_q.sn;
		cn1.c   = ox * ser_q.sn;
		cn1.d   = oy * ser_q.cs;
		cn1.px  = ser_q.px;
		cn1.py  = ser_q.py;
		cn1.idx = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (fe) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			p_s1 <= n1; p_s2 <= n2; p_s3 <= n3;
			p_s4 <= n4; p_s5 <= n5; p_s6 <= n6;
			ser_q <= p_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			cnt_q   <= CORNER_BL;
		end else if (en) begin
			if (fe) begin
				ser_v_q <= v_s6;
				cnt_q   <= CORNER_BL;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0; cv_s2 <= 1'b0; cv_s3 <= 1'b0;
		end else if (en) begin
			cv_s1 <= ser_v_q; cv_s2 <= cv_s1; cv_s3 <= cv_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] sx, sy;
		logic signed [SUM_W-1:0] tx, ty;
		logic signed [RES_W-1:0] rxv, ryv;
		if (en) begin
			c_s1 <= cn1;
			sx = SUM_W'(c_s1.a) - SUM_W'(c_s1.b);
			sy = SUM_W'(c_s1.c) + SUM_W'(c_s1.d);
			tx = (sx + SUM_W'(524288)) >>> 20;
			ty = (sy + SUM_W'(524288)) >>> 20;
			rx_s2  <= RES_W'(c_s1.px) + RES_W'(tx);
			ry_s2  <= RES_W'(c_s1.py) + RES_W'(ty);
			idx_s2 <= c_s1.idx;
			rxv = rx_s2;
			ryv = ry_s2;
			ox_s3 <= (rxv > RES_W'(2**(CB-1) - 1)) ? CB'(2**(CB-1) - 1) :
			         (rxv < -RES_W'(2**(CB-1))) ? CB'(2**(CB-1)) : rxv[CB-1:0];
			oy_s3 <= (ryv > RES_W'(2**(CB-1) - 1)) ? CB'(2**(CB-1) - 1) :
			         (ryv < -RES_W'(2**(CB-1))) ? CB'(2**(CB-1)) : ryv[CB-1:0];
			idx_s3 <= idx_s2;
		end
	end

	assign m_tvalid = cv_s3;
	assign m_tdata  = OUT_TW'({oy_s3, ox_s3});
	assign m_tuser  = idx_s3;
	assign m_tlast  = (idx_s3 == CORNER_TL);

endmodule

// ===== rtl/psct_checker.sv =====
module psct_checker
	import psct_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata,
	input logic [1:0]        m_tuser,
	input logic              m_tlast
);

	// The last flag marks the top-left corner and nothing else.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == CORNER_TL)))
		else $error("last flag does not match corner index");

	// A stalled output freezes the whole pipe, so no new sprite is taken.
	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("sprite accepted while output stalled");

	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled word changed");

endmodule

bind pivot_sprite_corner_transform psct_checker u_psct_checker (.*);

// ===== sim/tb_pivot_sprite_corner_transform.sv =====
module tb_pivot_sprite_corner_transform;
	import psct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int N_RANDOM = 152;
	localparam int N_DIRECTED = 18;
	localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef struct {
		longint px, py, w, h, pu, pv, ang;
		bit     mir;
	} sprite_req_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [1:0]                   idx;
		logic                         last;
	} corner_exp_t;

	// Directed rows with a corner typed in: whether it is used, and the values.
	typedef struct {
		sprite_req_t req;
		bit          has_bl;
		longint      bl_x, bl_y;
	} directed_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_TW-1:0] m_tdata;
	logic [1:0]        m_tuser;
	logic              m_tlast;

	corner_exp_t   corner_queue[$];
	longint        typed_bl_x[$];
	longint        typed_bl_y[$];
	bit            typed_bl_use[$];
	int            fail_count;
	int            idle_cycles;
	bit            stim_done;
	directed_row_t directed_rows[N_DIRECTED];

	pivot_sprite_corner_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Sine and cosine in Q1.16 from the quadrant and a 16-step rotation of its residual.
	task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
		longint atan_steps[16] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
			'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
			'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};
		logic [31:0] a;
		longint x, y, z, xs, ys, c, s;
		a = 32'(ang) << (32 - ANGLE_BITS);
		x = 652032874;
		y = 0;
		z = longint'(a & 32'h3FFF_FFFF);
		for (int i = 0; i < 16; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_steps[i];
			end else begin
				x += ys; y -= xs; z += atan_steps[i];
			end
		end
		c = clip(floor_shift(x + 8192, 14), -UNIT_Q16, UNIT_Q16);
		s = clip(floor_shift(y + 8192, 14), -UNIT_Q16, UNIT_Q16);
		case (a[31:30])
			2'd0: begin cs = c;  sn = s;  end
			2'd1: begin cs = -s; sn = c;  end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endtask

	task automatic predict_corners(input sprite_req_t r);
		longint pu, pv, sn, cs, lx, rx, ty, by, rxv, ryv;
		longint ox[4], oy[4];
		corner_exp_t e;
		pu = r.pu > UNIT_Q16 ? UNIT_Q16 : r.pu;
		pv = r.pv > UNIT_Q16 ? UNIT_Q16 : r.pv;
		cordic_sincos(r.ang, sn, cs);
		lx = floor_shift(-(pu * r.w) + 2048, 12);
		rx = floor_shift((UNIT_Q16 - pu) * r.w + 2048, 12);
		ty = floor_shift(pv * r.h + 2048, 12);
		by = floor_shift(pv * r.h - r.h * UNIT_Q16 + 2048, 12);
		if (r.mir) begin
			lx = -lx; rx = -rx;
		end
		ox = '{lx, rx, rx, lx};
		oy = '{by, by, ty, ty};
		for (int k = 0; k < 4; k++) begin
			rxv = ox[k] * cs - oy[k] * sn;
			ryv = ox[k] * sn + oy[k] * cs;
			e.cx = COORD_BITS'(clip(r.px + floor_shift(rxv + 524288, 20), CMIN, CMAX));
			e.cy = COORD_BITS'(clip(r.py + floor_shift(ryv + 524288, 20), CMIN, CMAX));
			e.idx = 2'(k);
			e.last = (k == 3);
			corner_queue.push_back(e);
		end
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30));
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_sprite(input sprite_req_t r, input bit has_bl, input longint bx,
			input longint by);
		s_tdata <= IN_TW'({16'(r.ang), 17'(r.pv), 17'(r.pu), 23'(r.h), 23'(r.w),
			24'(r.py), 24'(r.px)});
		s_tuser <= r.mir;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_corners(r);
		typed_bl_use.push_back(has_bl);
		typed_bl_x.push_back(bx);
		typed_bl_y.push_back(by);
	endtask

	function automatic sprite_req_t random_sprite();
		sprite_req_t r;
		int sel;
		sel = $urandom_range(0, 9);
		r.px = longint'($signed(24'($urandom)));
		r.py = longint'($signed(24'($urandom)));
		if (sel < 7) begin
			// Mostly modest sprites near a modest anchor, so that saturation stays rare.
			r.px = r.px >>> 6;
			r.py = r.py >>> 6;
			r.w = $urandom_range(0, 1 << 17);
			r.h = $urandom_range(0, 1 << 17);
		end else begin
			r.w = 23'($urandom);
			r.h = 23'($urandom);
		end
		r.pu = ($urandom_range(0, 7) == 0) ? 17'($urandom) : $urandom_range(0, UNIT_Q16);
		r.pv = ($urandom_range(0, 7) == 0) ? 17'($urandom) : $urandom_range(0, UNIT_Q16);
		r.ang = 16'($urandom);
		r.mir = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic sprite_req_t mk(longint px, longint py, longint w, longint h,
			longint pu, longint pv, longint ang, bit mir);
		sprite_req_t r;
		r.px = px; r.py = py; r.w = w; r.h = h;
		r.pu = pu; r.pv = pv; r.ang = ang; r.mir = mir;
		return r;
	endfunction

	initial begin
		// Zero size at angle zero: every corner sits on the anchor.
		directed_rows[0] = '{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0};
		// Pivot at the top-left, no rotation: bottom-left is at (px, py - h).
		directed_rows[1] = '{mk(256, 512, 2560, 1280, 0, 0, 0, 0), 1, 256, 512 - 1280};
		directed_rows[2] = '{mk(CMAX, CMAX, 8388607, 8388607, 0, 65536, 0, 0), 1, CMAX, CMAX};
		directed_rows[3] = '{mk(CMIN, CMIN, 8388607, 8388607, 65536, 0, 0, 0), 1, CMIN, CMIN};
		directed_rows[4] = '{mk(0, 0, 2560, 2560, 32768, 32768, 16384, 0), 0, 0, 0};
		directed_rows[5] = '{mk(0, 0, 2560, 2560, 32768, 32768, 32768, 1), 0, 0, 0};
		directed_rows[6] = '{mk(0, 0, 2560, 2560, 32768, 32768, 49152, 0), 0, 0, 0};
		directed_rows[7] = '{mk(0, 0, 2560, 2560, 32768, 32768, 65535, 1), 0, 0, 0};
		// Pivots above one saturate to one.
		directed_rows[8] = '{mk(100, -100, 4096, 4096, 131071, 131071, 1000, 0), 0, 0, 0};
		directed_rows[9] = '{mk(100, -100, 4096, 4096, 65537, 98304, 1000, 1), 0, 0, 0};
		directed_rows[10] = '{mk(CMAX, CMIN, 8388607, 8388607, 32768, 32768, 8192, 1), 0, 0, 0};
		directed_rows[11] = '{mk(CMIN, CMAX, 8388607, 8388607, 32768, 32768, 40000, 0), 0, 0, 0};
		directed_rows[12] = '{mk(-1, -1, 1, 1, 65536, 65536, 1, 1), 0, 0, 0};
		directed_rows[13] = '{mk(0, 0, 0, 0, 0, 0, 12345, 0), 0, 0, 0};
		directed_rows[14] = '{mk(1000, 2000, 8388607, 0, 65536, 0, 24576, 1), 0, 0, 0};
		directed_rows[15] = '{mk(-5000, 7000, 0, 8388607, 0, 65536, 57344, 0), 0, 0, 0};
		directed_rows[16] = '{mk(0, 0, 5000, 3000, 20000, 50000, 32767, 0), 0, 0, 0};
		directed_rows[17] = '{mk(0, 0, 5000, 3000, 20000, 50000, 16385, 1), 0, 0, 0};
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		stim_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_sprite(directed_rows[i].req, directed_rows[i].has_bl,
				directed_rows[i].bl_x, directed_rows[i].bl_y);
			if (i % 3 == 0) idle_gap();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// Let the pipeline drain completely before carrying on.
				s_tvalid <= 1'b0;
				while (corner_queue.size() != 0) @(posedge clk);
			end
			send_sprite(random_sprite(), 0, 0, 0);
			if ($urandom_range(0, 3) != 0) idle_gap();
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Output stall pattern: bursts of ready, short drops and an occasional long hold.
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			m_tready <= 1'b0;
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		corner_exp_t e;
		logic signed [COORD_BITS-1:0] got_x, got_y;
		if (arst_n && m_tvalid && m_tready) begin
			got_x = m_tdata[COORD_BITS-1:0];
			got_y = m_tdata[2*COORD_BITS-1:COORD_BITS];
			if (corner_queue.size() == 0) begin
				$error("corner word with no sprite outstanding: x=%0d y=%0d", got_x, got_y);
				fail_count++;
			end else begin
				e = corner_queue.pop_front();
				if (e.idx == CORNER_BL && typed_bl_use.pop_front()) begin
					e.cx = COORD_BITS'(typed_bl_x.pop_front());
					e.cy = COORD_BITS'(typed_bl_y.pop_front());
				end else if (e.idx == CORNER_BL) begin
					void'(typed_bl_x.pop_front());
					void'(typed_bl_y.pop_front());
				end
				if (got_x !== e.cx) begin
					$error("corner_x: expected %0d, got %0d", e.cx, got_x);
					fail_count++;
				end
				if (got_y !== e.cy) begin
					$error("corner_y: expected %0d, got %0d", e.cy, got_y);
					fail_count++;
				end
				if (m_tuser !== e.idx) begin
					$error("corner_index: expected %0d, got %0d", e.idx, m_tuser);
					fail_count++;
				end
				if (m_tlast !== e.last) begin
					$error("last_corner: expected %0d, got %0d", e.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog expired with %0d corners outstanding", corner_queue.size());
				$display("** pivot_sprite_corner_transform: FAILED **");
				$finish;
			end
			if (stim_done && corner_queue.size() == 0) begin
				repeat (30) @(posedge clk);
				if (fail_count == 0 && corner_queue.size() == 0)
					$display("** pivot_sprite_corner_transform: PASSED **");
				else
					$display("** pivot_sprite_corner_transform: FAILED **");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
rtl/psct_pkg.sv
rtl/pivot_sprite_corner_transform.sv
rtl/psct_checker.sv
sim/tb_pivot_sprite_corner_transform.sv
